// ----- hdl/mm4_pkg.sv -----
// Shared types and constants for the 4x4 fixed-point matrix multiply unit.
package mm4_pkg;

    // Default matrix dimension; the top level takes it as a parameter.
    localparam int DIM_DEFAULT = 4;

    // Fixed-point format: signed Q16.16 words.
    localparam int WORD_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * WORD_W;

    // One input word: an element of each source matrix at the same index.
    typedef struct packed {
        logic signed [WORD_W-1:0] left_value;
        logic signed [WORD_W-1:0] right_value;
    } load_word_t;

    // One result word: a product element and the end-of-matrix mark.
    typedef struct packed {
        logic signed [WORD_W-1:0] product_value;
        logic                     last_out;
    } result_word_t;

    // Control that travels with each operand pair into the MAC unit.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

// ----- hdl/matrix_multiply_4x4_unit.sv -----
// Top level of the DIM x DIM Q16.16 matrix multiply unit with its sequencer.
//
//   Channel   Signals                               Word contents
//   load      load_valid, load_ready, load_word     left_value, right_value
//   result    result_valid, result_ready, result_word  product_value, last_out
//
// Loading accepts a word whenever load_valid and load_ready are both high; DIM*DIM
// words fill both operand memories. Each product element is then issued as DIM
// operand pairs to the shared multiplier and passes through the read, multiply,
// accumulate and clamp registers; the next element is issued only after the
// sum is handed off, so the single multiply-accumulate unit sets the pace.
// load_ready is low from the last load word until the final element is in the
// output register; a stalled result channel holds the sequencer.
// Reset clears the sequencer and valid flags; the memories are not cleared.
module matrix_multiply_4x4_unit
    import mm4_pkg::*;
#(
    parameter int DIM = DIM_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load_valid,
    output logic         load_ready,
    input  load_word_t   load_word,
    output logic         result_valid,
    input  logic         result_ready,
    output result_word_t result_word
);

    localparam int ELEMS = DIM * DIM;
    localparam int IDX_W = $clog2(ELEMS);
    localparam int CNT_W = $clog2(DIM);

    // Sequencer state codes.
    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;

    logic [1:0]               state_reg;
    logic [1:0]               state_next;
    logic [IDX_W-1:0]         load_count_reg;
    logic [IDX_W-1:0]         load_count_next;
    logic [CNT_W-1:0]         row_reg;
    logic [CNT_W-1:0]         row_next;
    logic [CNT_W-1:0]         col_reg;
    logic [CNT_W-1:0]         col_next;
    logic [CNT_W-1:0]         e_reg;
    logic [CNT_W-1:0]         e_next;

    logic signed [WORD_W-1:0] left_mem  [ELEMS];
    logic signed [WORD_W-1:0] right_mem [ELEMS];
    logic [IDX_W-1:0]         left_addr;
    logic [IDX_W-1:0]         right_addr;
    logic signed [WORD_W-1:0] left_rd_reg;
    logic signed [WORD_W-1:0] right_rd_reg;

    mac_ctl_t                 issue_ctl;
    mac_ctl_t                 rd_ctl_reg;
    logic                     mac_take;
    logic                     mac_res_valid;
    logic signed [WORD_W-1:0] mac_res;

    logic                     load_fire;
    logic                     out_free;
    logic                     row_last;
    logic                     col_last;
    logic                     e_last;

    logic                     result_valid_reg;
    logic                     result_valid_next;
    result_word_t             result_word_reg;

    assign load_ready = (state_reg == ST_LOAD);
    assign load_fire  = load_valid && load_ready;
    assign out_free   = !result_valid_reg || result_ready;
    assign row_last   = (row_reg == CNT_W'(DIM - 1));
    assign col_last   = (col_reg == CNT_W'(DIM - 1));
    assign e_last     = (e_reg == CNT_W'(DIM - 1));
    assign mac_take   = (state_reg == ST_WAIT) && mac_res_valid && out_free;

    // Operand addresses: A walks a row, B walks a column.
    assign left_addr  = IDX_W'(row_reg) + IDX_W'(e_reg) * IDX_W'(DIM);
    assign right_addr = IDX_W'(e_reg) + IDX_W'(col_reg) * IDX_W'(DIM);

    // Operand memories: written while loading, read one pair per issue cycle.
    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            left_mem[load_count_reg]  <= load_word.left_value;
            right_mem[load_count_reg] <= load_word.right_value;
        end
        left_rd_reg  <= left_mem[left_addr];
        right_rd_reg <= right_mem[right_addr];
    end

    // Control for the operand pair being read this cycle.
    always_comb
    begin
        issue_ctl       = '0;
        issue_ctl.valid = (state_reg == ST_ISSUE);
        issue_ctl.first = (e_reg == '0);
        issue_ctl.last  = e_last;
    end

    // Sequencer: load, issue DIM operand pairs, wait for and hand off the sum.
    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        e_next          = e_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (load_fire)
                begin
                    if (load_count_reg == IDX_W'(ELEMS - 1))
                    begin
                        load_count_next = '0;
                        state_next      = ST_ISSUE;
                    end
                    else
                    begin
                        load_count_next = load_count_reg + 1'b1;
                    end
                end
            end
            ST_ISSUE:
            begin
                if (e_last)
                begin
                    e_next     = '0;
                    state_next = ST_WAIT;
                end
                else
                begin
                    e_next = e_reg + 1'b1;
                end
            end
            ST_WAIT:
            begin
                if (mac_take)
                begin
                    if (row_last)
                    begin
                        row_next = '0;
                        if (col_last)
                        begin
                            col_next   = '0;
                            state_next = ST_LOAD;
                        end
                        else
                        begin
                            col_next   = col_reg + 1'b1;
                            state_next = ST_ISSUE;
                        end
                    end
                    else
                    begin
                        row_next   = row_reg + 1'b1;
                        state_next = ST_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            load_count_reg <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            e_reg          <= '0;
            rd_ctl_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            e_reg          <= e_next;
            rd_ctl_reg     <= issue_ctl;
        end
    end

    // Shared multiply-accumulate unit.
    mm4_mac #(
        .DIM (DIM)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (rd_ctl_reg),
        .a         (left_rd_reg),
        .b         (right_rd_reg),
        .take      (mac_take),
        .res_valid (mac_res_valid),
        .res       (mac_res)
    );

    // Output register: one result word, held while the consumer stalls.
    always_comb
    begin
        if (mac_take)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mac_take)
        begin
            result_word_reg.product_value <= mac_res;
            result_word_reg.last_out      <= row_last && col_last;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_word  = result_word_reg;

    // The MAC never holds a finished sum while the block is loading.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> !mac_res_valid)
        else $error("MAC result pending while loading");

    // A waiting result word holds still until the receiver takes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result_word)))
        else $error("result word changed while stalled");

    // The term counter only moves while operand pairs are being issued.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ISSUE) |-> (e_reg == '0))
        else $error("term counter nonzero outside issue");

    // After a hand-off the output register holds a valid word and the MAC result flag is clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        mac_take |=> (result_valid && !mac_res_valid))
        else $error("hand-off of MAC result did not complete");

endmodule

// ----- hdl/mm4_mac.sv -----
// Shared multiply-accumulate unit with Q16.16 rescale and saturation.
module mm4_mac
    import mm4_pkg::*;
#(
    parameter int DIM = DIM_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_ctl_t                 ctl,
    input  logic signed [WORD_W-1:0] a,
    input  logic signed [WORD_W-1:0] b,
    input  logic                     take,
    output logic                     res_valid,
    output logic signed [WORD_W-1:0] res
);

    // The exact sum of DIM products needs $clog2(DIM) guard bits over one product.
    localparam int ACC_W = PROD_W + $clog2(DIM);

    mac_ctl_t                 prod_ctl_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     fin_reg;
    logic                     res_valid_reg;
    logic signed [WORD_W-1:0] res_reg;
    logic signed [ACC_W-1:0]  shifted;
    logic                     ovf;
    logic signed [WORD_W-1:0] sat_val;

    // Stage one: the 32x32 signed product.
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_ctl_reg <= '0;
        end
        else
        begin
            prod_ctl_reg <= ctl;
        end
    end

    // Stage two: exact accumulation, restarted on the first term of an element.
    always_comb
    begin
        acc_next = acc_reg;
        if (prod_ctl_reg.valid)
        begin
            if (prod_ctl_reg.first)
            begin
                acc_next = ACC_W'(prod_reg);
            end
            else
            begin
                acc_next = acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_reg <= 1'b0;
        end
        else
        begin
            fin_reg <= prod_ctl_reg.valid && prod_ctl_reg.last;
        end
    end

    // Stage three: floor shift by the fraction width, then clamp to 32 bits.
    always_comb
    begin
        shifted = acc_reg >>> FRAC_BITS;
        ovf     = (shifted[ACC_W-1:WORD_W-1] != '0) && (shifted[ACC_W-1:WORD_W-1] != '1);
        if (ovf)
        begin
            sat_val = shifted[ACC_W-1] ? {1'b1, {(WORD_W-1){1'b0}}}
                                       : {1'b0, {(WORD_W-1){1'b1}}};
        end
        else
        begin
            sat_val = shifted[WORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_reg)
        begin
            res_reg <= sat_val;
        end
    end

    // The result is held until the sequencer takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (fin_reg)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- verif/tb_matrix_multiply_4x4_unit.sv -----
// Self-checking testbench for the 4x4 Q16.16 matrix multiply unit.
module tb_matrix_multiply_4x4_unit;
    import mm4_pkg::*;

    localparam int DIM          = DIM_DEFAULT;
    localparam int ELEMS        = DIM * DIM;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4 * (DIM + 5);
    localparam int SHOW_LIMIT   = 10;

    localparam logic signed [WORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [WORD_W-1:0] Q_ULP = 32'sh0000_0001;

    // Sums of DIM products of two 32-bit words are held with four guard bits.
    localparam logic signed [PROD_W+3:0] SUM_MAX = Q_MAX;
    localparam logic signed [PROD_W+3:0] SUM_MIN = Q_MIN;

    // Kinds of element values drawn for a random matrix.
    typedef enum int {VK_SMALL, VK_FULL, VK_EXTREME, VK_MIXED} value_kind_t;

    // Behaviors of the result channel receiver.
    typedef enum int {RM_ALWAYS, RM_COIN, RM_SPARSE, RM_LONG_HOLD} ready_mode_t;

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         load_valid   = 1'b0;
    logic         load_ready;
    load_word_t   load_word    = '0;
    logic         result_valid;
    logic         result_ready = 1'b0;
    result_word_t result_word;

    // Predictor state: operand memories and the index of the next load word.
    logic signed [WORD_W-1:0] left_mem  [ELEMS];
    logic signed [WORD_W-1:0] right_mem [ELEMS];
    int                       fill_index = 0;
    result_word_t             product_queue [$];

    int          mismatch_count = 0;
    int          cycle_count    = 0;
    bit          sender_gaps    = 1'b0;
    int          burst_left     = 0;
    ready_mode_t ready_mode     = RM_ALWAYS;
    int          mode_left      = 0;
    int          hold_left      = 0;

    matrix_multiply_4x4_unit #(.DIM(DIM)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_valid   (load_valid),
        .load_ready   (load_ready),
        .load_word    (load_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word)
    );

    // Free-running clock, period 20.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit; a hung handshake ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_matrix_multiply_4x4_unit NOT OK");
            $finish;
        end
    end

    // One product element: exact sum of products, floor shift, then clamp.
    function automatic logic signed [WORD_W-1:0] product_element(input int row, input int col);
        logic signed [PROD_W-1:0] term;
        logic signed [PROD_W+3:0] sum;
        logic signed [PROD_W+3:0] scaled;
        sum = '0;
        for (int e = 0; e < DIM; e++)
        begin
            term = left_mem[row + e * DIM] * right_mem[e + col * DIM];
            sum  = sum + term;
        end
        scaled = sum >>> FRAC_BITS;
        if (scaled > SUM_MAX)
            scaled = SUM_MAX;
        else if (scaled < SUM_MIN)
            scaled = SUM_MIN;
        return scaled[WORD_W-1:0];
    endfunction

    // Store an accepted load word; a completed set queues the whole product.
    function automatic void record_load(input load_word_t w);
        result_word_t elem;
        left_mem[fill_index]  = w.left_value;
        right_mem[fill_index] = w.right_value;
        if (fill_index == ELEMS - 1)
        begin
            fill_index = 0;
            for (int col = 0; col < DIM; col++)
            begin
                for (int row = 0; row < DIM; row++)
                begin
                    elem.product_value = product_element(row, col);
                    elem.last_out      = (row + col * DIM == ELEMS - 1);
                    product_queue.push_back(elem);
                end
            end
        end
        else
        begin
            fill_index++;
        end
    endfunction

    // Compare a result word with the oldest expected product element.
    function automatic void check_result(input result_word_t got);
        result_word_t want;
        if (product_queue.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= SHOW_LIMIT)
                $display("unexpected result word: product_value %0d last_out %0b",
                         got.product_value, got.last_out);
        end
        else
        begin
            want = product_queue.pop_front();
            if (got.product_value !== want.product_value || got.last_out !== want.last_out)
            begin
                mismatch_count++;
                if (mismatch_count <= SHOW_LIMIT)
                    $display("result mismatch: expected %0d/%0b, got %0d/%0b",
                             want.product_value, want.last_out,
                             got.product_value, got.last_out);
            end
        end
    endfunction

    // Watch both channels at each rising edge.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            check_result(result_word);
        if (rst_n && load_valid && load_ready)
            record_load(load_word);
    end

    // Receiver: switches at random between stall behaviors.
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(50, 250);
        end
        else
        begin
            mode_left--;
        end
        case (ready_mode)
            RM_ALWAYS: result_ready <= 1'b1;
            RM_COIN:   result_ready <= 1'($urandom_range(0, 1));
            RM_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (hold_left > 0)
                begin
                    hold_left--;
                    result_ready <= 1'b0;
                end
                else
                begin
                    if ($urandom_range(0, 7) == 0)
                        hold_left = $urandom_range(10, 30);
                    result_ready <= 1'b1;
                end
            end
        endcase
    end

    // Draw one element value of the requested kind.
    function automatic logic signed [WORD_W-1:0] random_element(input value_kind_t kind);
        logic signed [WORD_W-1:0] v;
        value_kind_t              pick;
        pick = kind;
        if (pick == VK_MIXED)
            pick = value_kind_t'($urandom_range(0, 2));
        case (pick)
            VK_SMALL:
            begin
                v = $urandom_range(0, 32'h0008_0000);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            VK_FULL:
                v = $urandom();
            default:
            begin
                case ($urandom_range(0, 6))
                    0:       v = Q_MAX;
                    1:       v = Q_MIN;
                    2:       v = '0;
                    3:       v = -Q_ULP;
                    4:       v = Q_ULP;
                    5:       v = Q_ONE;
                    default: v = -Q_ONE;
                endcase
            end
        endcase
        return v;
    endfunction

    // Send one load word and wait for it to be taken; idle between bursts.
    task automatic load_pair(input logic signed [WORD_W-1:0] left,
                             input logic signed [WORD_W-1:0] right);
        load_word_t w;
        int         gap;
        w.left_value  = left;
        w.right_value = right;
        load_valid <= 1'b1;
        load_word  <= w;
        @(posedge clk);
        while (!load_ready)
            @(posedge clk);
        if (sender_gaps)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 12);
                load_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // Hold the sender until every expected product element has come back.
    task automatic wait_results_drained();
        load_valid <= 1'b0;
        @(posedge clk);
        while (product_queue.size() != 0)
            @(posedge clk);
    endtask

    // Load one full pair of matrices with random elements.
    task automatic send_matrix_set(input value_kind_t kind);
        for (int idx = 0; idx < ELEMS; idx++)
            load_pair(random_element(kind), random_element(kind));
    endtask

    // Rows and columns of extremes: both saturation directions, floor of a
    // tiny negative sum, and the largest possible exact sum.
    task automatic test_directed_extremes();
        logic signed [WORD_W-1:0] left;
        logic signed [WORD_W-1:0] right;
        int                       lo;
        int                       hi;
        sender_gaps = 1'b0;
        for (int idx = 0; idx < ELEMS; idx++)
        begin
            lo = idx % DIM;
            hi = idx / DIM;
            case (lo)
                0:       left = Q_MAX;
                1:       left = Q_MIN;
                2:       left = -Q_ULP;
                default: left = Q_ONE;
            endcase
            case (hi)
                0:       right = Q_MAX;
                1:       right = Q_MIN;
                2:       right = Q_ULP;
                default: right = (lo == DIM - 1) ? Q_ONE : '0;
            endcase
            load_pair(left, right);
        end
        wait_results_drained();
    endtask

    // Values of magnitude at most eight, sender idling in bursts.
    task automatic test_small_values();
        sender_gaps = 1'b1;
        repeat (10) send_matrix_set(VK_SMALL);
    endtask

    // Full-range words back to back, so products saturate often.
    task automatic test_full_range();
        sender_gaps = 1'b0;
        repeat (8) send_matrix_set(VK_FULL);
    endtask

    // Random left matrix times identity must return the left matrix.
    task automatic test_identity_products();
        sender_gaps = 1'b1;
        repeat (2)
        begin
            for (int idx = 0; idx < ELEMS; idx++)
                load_pair(random_element(VK_FULL),
                          (idx % DIM == idx / DIM) ? Q_ONE : '0);
        end
        wait_results_drained();
    endtask

    // Mixed kinds, with the sender pausing for a full drain now and then.
    task automatic test_mixed_values();
        sender_gaps = 1'b1;
        for (int set = 0; set < 8; set++)
        begin
            send_matrix_set(VK_MIXED);
            if (set % 3 == 2)
                wait_results_drained();
        end
    endtask

    // Test sequence and final verdict.
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_small_values();
        test_full_range();
        test_identity_products();
        test_mixed_values();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && product_queue.size() == 0)
            $display("tb_matrix_multiply_4x4_unit OK");
        else
            $display("tb_matrix_multiply_4x4_unit NOT OK");
        $finish;
    end

endmodule
